/* design/mm_pkg.sv */
`timescale 1ns / 1ps

package mm_pkg;

   localparam int MATRIX_DIM_DEF = 64;

   localparam int ROW_W   = 6;
   localparam int COL_W   = 6;
   localparam int ELEM_W  = 16;
   localparam int PROD_W  = 32;
   localparam int ACC_W   = 48;
   localparam int OUT_W   = 32;
   localparam int SIZE_W  = 7;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   localparam logic [OUT_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [OUT_W-1:0] SAT_MIN = 32'h8000_0000;

   typedef enum logic [0:0] {
      CMD_LOAD    = 1'b0,
      CMD_COMPUTE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic data_vld;
   } mac_ctl_type;

   typedef struct packed {
      logic busy;
      logic saturated;
   } mac_sts_type;

endpackage

/* design/matrix_multiply.sv */
`timescale 1ns / 1ps

// Matrix product engine: answers one element of C = A x B per compute transaction.
// Request channel (req_valid/req_ready): req_cmd selects load or compute.
//   A load writes req_a_value into A and req_b_value into B at (req_row, req_col);
//   indexes at or beyond MATRIX_DIM are dropped.
//   A compute returns the dot product of row req_row of A and column req_col of B
//   over n = min(csr size, MATRIX_DIM) terms, saturated to signed Q16.16.
// Response channel (rsp_valid/rsp_ready): one transaction per compute, none per load.
// A compute streams its terms through one shared multiply-accumulate unit, which
// consumes one term a cycle, behind a registered store read and a product register.
// Out-of-range indexes or n = 0 skip the terms and answer 0.
// req_ready is high only while the sequencer is idle; a finished result sits in
// the output register, so loads and a new compute are taken while the receiver
// stalls, and a compute only waits at its end for the output register to free up.
// Reset clears the sequencer and the response valid and sets the size to 64.
// The stores are not cleared; an entry must be loaded before a compute reads it.
// csr_wr_en writes csr_wr_data into the size register; write only when idle.

module matrix_multiply #(
   parameter int MATRIX_DIM = mm_pkg::MATRIX_DIM_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic        [mm_pkg::SIZE_W-1:0]    csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic        [mm_pkg::ROW_W-1:0]     req_row,
   input  logic        [mm_pkg::COL_W-1:0]     req_col,
   input  logic signed [mm_pkg::ELEM_W-1:0]    req_a_value,
   input  logic signed [mm_pkg::ELEM_W-1:0]    req_b_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [mm_pkg::OUT_W-1:0]     rsp_product_value,
   output logic                                rsp_saturated
);

   localparam int DEPTH  = MATRIX_DIM * MATRIX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int DIM_W  = $clog2(MATRIX_DIM + 1);

   mm_pkg::state_type             state_ff, state_in;
   mm_pkg::mac_ctl_type           mac_ctl;
   mm_pkg::mac_sts_type           mac_sts;

   logic [mm_pkg::SIZE_W-1:0]     size_ff;
   logic [DIM_W-1:0]              n_ff, n_in;
   logic [DIM_W-1:0]              kcnt_ff, kcnt_in;
   logic [ADDR_W-1:0]             a_addr_ff, a_addr_in;
   logic [ADDR_W-1:0]             b_addr_ff, b_addr_in;
   logic                          rd_vld_ff;
   logic signed [mm_pkg::ELEM_W-1:0] a_rd_ff, b_rd_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mm_pkg::OUT_W-1:0]      rsp_value_ff;
   logic                          rsp_sat_ff;
   logic [mm_pkg::OUT_W-1:0]      sat_value;

   logic                          accept, is_compute, in_range, rd_en, out_load;
   logic [DIM_W-1:0]              n_eff;
   logic [ADDR_W-1:0]             ld_addr;

   logic [mm_pkg::ELEM_W-1:0]     a_mem [DEPTH];
   logic [mm_pkg::ELEM_W-1:0]     b_mem [DEPTH];

   assign accept     = req_valid && req_ready;
   assign is_compute = (req_cmd == mm_pkg::CMD_COMPUTE);
   assign in_range   = (32'(req_row) < 32'(MATRIX_DIM)) && (32'(req_col) < 32'(MATRIX_DIM));
   assign ld_addr    = ADDR_W'(32'(req_row) * 32'(MATRIX_DIM) + 32'(req_col));
   assign n_eff      = (32'(size_ff) < 32'(MATRIX_DIM)) ? DIM_W'(size_ff)
                     : DIM_W'(MATRIX_DIM);

   // size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= mm_pkg::SIZE_RESET;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   // element stores, registered read
   always_ff @(posedge clock) begin
      if (accept && !is_compute && in_range) begin
         a_mem[ld_addr] <= req_a_value;
         b_mem[ld_addr] <= req_b_value;
      end
      if (rd_en) begin
         a_rd_ff <= a_mem[a_addr_ff];
         b_rd_ff <= b_mem[b_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mm_pkg::ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
         kcnt_ff      <= kcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
      if (out_load) begin
         rsp_value_ff <= sat_value;
         rsp_sat_ff   <= mac_sts.saturated;
      end
   end

   always_comb begin
      state_in         = state_ff;
      req_ready        = 1'b0;
      rd_en            = 1'b0;
      out_load         = 1'b0;
      mac_ctl.clear    = 1'b0;
      mac_ctl.data_vld = rd_vld_ff;
      kcnt_in          = kcnt_ff;
      n_in             = n_ff;
      a_addr_in        = a_addr_ff;
      b_addr_in        = b_addr_ff;
      case (state_ff)
         mm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && is_compute) begin
               mac_ctl.clear = 1'b1;
               kcnt_in       = '0;
               n_in          = n_eff;
               a_addr_in     = ADDR_W'(32'(req_row) * 32'(MATRIX_DIM));
               b_addr_in     = ADDR_W'(req_col);
               state_in      = (in_range && (n_eff != '0)) ? mm_pkg::ST_RUN
                             : mm_pkg::ST_FINISH;
            end
         end
         mm_pkg::ST_RUN: begin
            // issue one term per cycle: walk along the row of A, down the column of B
            rd_en     = 1'b1;
            kcnt_in   = kcnt_ff + DIM_W'(1);
            a_addr_in = a_addr_ff + ADDR_W'(1);
            b_addr_in = b_addr_ff + ADDR_W'(MATRIX_DIM);
            if (kcnt_ff == n_ff - DIM_W'(1)) begin
               state_in = mm_pkg::ST_DRAIN;
            end
         end
         mm_pkg::ST_DRAIN: begin
            if (!rd_vld_ff && !mac_sts.busy) begin
               state_in = mm_pkg::ST_FINISH;
            end
         end
         mm_pkg::ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = mm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   mm_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .mac_ctl   (mac_ctl),
      .a_data    (a_rd_ff),
      .b_data    (b_rd_ff),
      .mac_sts   (mac_sts),
      .sat_value (sat_value)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_saturated     = rsp_sat_ff;

   a_rd_in_run: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == mm_pkg::ST_RUN || state_ff == mm_pkg::ST_DRAIN))
      else $error("store read data valid outside of a compute");

   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mm_pkg::ST_FINISH) |-> (!rd_vld_ff && !mac_sts.busy))
      else $error("result taken before the MAC pipeline drained");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mm_pkg::ST_RUN) |-> (kcnt_ff < n_ff))
      else $error("term counter ran past the dot product length");

   a_result_posted: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_valid && state_ff == mm_pkg::ST_IDLE))
      else $error("finished compute did not post a response");

endmodule

/* design/mm_mac.sv */
`timescale 1ns / 1ps

module mm_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  mm_pkg::mac_ctl_type                 mac_ctl,
   input  logic signed [mm_pkg::ELEM_W-1:0]    a_data,
   input  logic signed [mm_pkg::ELEM_W-1:0]    b_data,
   output mm_pkg::mac_sts_type                 mac_sts,
   output logic        [mm_pkg::OUT_W-1:0]     sat_value
);

   logic                                prod_vld_ff;
   logic signed [mm_pkg::PROD_W-1:0]    prod_ff;
   logic signed [mm_pkg::ACC_W-1:0]     acc_ff;
   logic signed [mm_pkg::ACC_W-1:0]     acc_in;
   logic        [mm_pkg::ACC_W-mm_pkg::OUT_W:0] acc_top;
   logic                                fits;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= mac_ctl.data_vld;
      end
   end

   // product stage, then accumulate stage
   always_ff @(posedge clock) begin
      prod_ff <= a_data * b_data;
      acc_ff  <= acc_in;
   end

   always_comb begin
      acc_in = acc_ff;
      if (mac_ctl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + mm_pkg::ACC_W'(prod_ff);
      end
   end

   // sum fits in 32 bits when the top bits are all sign copies
   assign acc_top = acc_ff[mm_pkg::ACC_W-1:mm_pkg::OUT_W-1];
   assign fits    = (&acc_top) || !(|acc_top);

   assign sat_value = fits ? acc_ff[mm_pkg::OUT_W-1:0]
                    : (acc_ff[mm_pkg::ACC_W-1] ? mm_pkg::SAT_MIN : mm_pkg::SAT_MAX);

   assign mac_sts.busy      = prod_vld_ff;
   assign mac_sts.saturated = !fits;

endmodule
